// ===== sv/poc_pkg.sv =====
// shared constants and types for the order crossover core
// no dependencies
package poc_pkg;

  localparam int CITY_COUNT  = 32;
  localparam int STORE_DEPTH = 32;
  localparam int TOUR_LEN_I  = (CITY_COUNT > STORE_DEPTH) ? STORE_DEPTH :
                               ((CITY_COUNT < 4) ? 4 : CITY_COUNT);

  localparam int CITY_W     = 5;
  localparam int CUT_W      = 6;
  localparam int MARK_W     = 1 << CITY_W;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [CUT_W-1:0]  TOUR_LEN = CUT_W'(TOUR_LEN_I);
  localparam logic [CUT_W-1:0]  CUT_LO   = CUT_W'(TOUR_LEN_I / 2);
  localparam logic [CUT_W-1:0]  CUT_HI   = CUT_W'(TOUR_LEN_I - 2);
  localparam logic [CITY_W-1:0] LAST_POS = CITY_W'(TOUR_LEN_I - 1);

  typedef logic [CITY_W-1:0] city_t;
  typedef logic [MARK_W-1:0] mark_t;

endpackage

// ===== sv/permutation_order_crossover_core.sv =====
// one-point order crossover of two city tours, single sequencer with one compare unit
// depends on poc_pkg
//
// usage: the input stream carries one parent position pair per transaction
// (position, first parent city, second parent city); tlast marks the final pair
// and its cut field gives the cut point, clamped to [len/2, len-2].
// pairs load at one per cycle while in_tready is high. after the last pair the
// core drops in_tready and runs three passes over its stores, each step a read
// phase then an update phase: prefix marking over the first cut positions, child
// fill scan over positions 1 to len-1 and the emit pass, one output transaction
// per position with tlast on the final position.
// the pace is set by the single read port of each store, one address per step.
// a stalled receiver holds the emit pass; the output register keeps its
// transaction until taken, and in_tready returns after the final one is loaded.
// reset clears the sequencer, the output valid and the prefix marks; the parent
// stores hold nothing defined until written.
module permutation_order_crossover_core
  import poc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // position, city_first, city_second, cut
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_position, child_first, child_second
  output logic                  out_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MARK = 2'd1;
  localparam logic [1:0] ST_FILL = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  city_t first_mem  [STORE_DEPTH];
  city_t second_mem [STORE_DEPTH];
  city_t child1_mem [STORE_DEPTH];
  city_t child2_mem [STORE_DEPTH];

  city_t first_q_r, second_q_r, child1_q_r, child2_q_r;

  logic [1:0]       state_r, state_nxt;
  logic             phase_r, phase_nxt;
  city_t            idx_r, idx_nxt;
  logic [CUT_W-1:0] cut_r, cut_nxt;
  logic [CUT_W-1:0] slot1_r, slot1_nxt;
  logic [CUT_W-1:0] slot2_r, slot2_nxt;
  mark_t            marks1_r, marks1_nxt;
  mark_t            marks2_r, marks2_nxt;
  logic             out_valid_r, out_valid_nxt;
  city_t            out_pos_r, out_c1_r, out_c2_r;
  logic             out_last_r;

  city_t            in_pos, in_c1, in_c2;
  logic [CUT_W-1:0] in_cut, cut_clamped;
  logic             in_acc, par_we;
  logic             c1_we, c2_we;
  logic             out_load;
  logic [CUT_W-1:0] idx_ext;
  city_t            sel_c1, sel_c2;

  assign in_pos = in_tdata[CITY_W-1:0];
  assign in_c1  = in_tdata[2*CITY_W-1:CITY_W];
  assign in_c2  = in_tdata[3*CITY_W-1:2*CITY_W];
  assign in_cut = in_tdata[3*CITY_W+CUT_W-1:3*CITY_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign par_we    = in_acc && ({1'b0, in_pos} < TOUR_LEN);
  assign idx_ext   = {1'b0, idx_r};

  always_comb begin
    if (in_cut < CUT_LO) begin
      cut_clamped = CUT_LO;
    end else if (in_cut > CUT_HI) begin
      cut_clamped = CUT_HI;
    end else begin
      cut_clamped = in_cut;
    end
  end

  // fill scan compare: donor city not in the other parent's prefix and a free slot left
  assign c1_we = (state_r == ST_FILL) && phase_r && !marks1_r[second_q_r] &&
                 (slot1_r < TOUR_LEN);
  assign c2_we = (state_r == ST_FILL) && phase_r && !marks2_r[first_q_r] &&
                 (slot2_r < TOUR_LEN);

  assign sel_c1 = ((idx_ext >= cut_r) && (idx_ext < slot1_r)) ? child1_q_r : first_q_r;
  assign sel_c2 = ((idx_ext >= cut_r) && (idx_ext < slot2_r)) ? child2_q_r : second_q_r;

  assign out_load = (state_r == ST_EMIT) && phase_r && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    cut_nxt    = cut_r;
    slot1_nxt  = slot1_r;
    slot2_nxt  = slot2_r;
    marks1_nxt = marks1_r;
    marks2_nxt = marks2_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tlast) begin
          state_nxt  = ST_MARK;
          phase_nxt  = 1'b0;
          idx_nxt    = '0;
          cut_nxt    = cut_clamped;
          marks1_nxt = '0;
          marks2_nxt = '0;
        end
      end
      ST_MARK: begin
        phase_nxt = !phase_r;
        if (phase_r) begin
          marks1_nxt = marks1_r | (MARK_W'(1) << first_q_r);
          marks2_nxt = marks2_r | (MARK_W'(1) << second_q_r);
          if (idx_ext == cut_r - CUT_W'(1)) begin
            state_nxt = ST_FILL;
            idx_nxt   = CITY_W'(1);
            slot1_nxt = cut_r;
            slot2_nxt = cut_r;
          end else begin
            idx_nxt = idx_r + CITY_W'(1);
          end
        end
      end
      ST_FILL: begin
        phase_nxt = !phase_r;
        if (phase_r) begin
          if (c1_we) begin
            slot1_nxt = slot1_r + CUT_W'(1);
          end
          if (c2_we) begin
            slot2_nxt = slot2_r + CUT_W'(1);
          end
          if (idx_r == LAST_POS) begin
            state_nxt = ST_EMIT;
            idx_nxt   = '0;
          end else begin
            idx_nxt = idx_r + CITY_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (!phase_r) begin
          phase_nxt = 1'b1;
        end else if (out_load) begin
          phase_nxt = 1'b0;
          if (idx_r == LAST_POS) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + CITY_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      idx_r       <= '0;
      cut_r       <= CUT_LO;
      slot1_r     <= '0;
      slot2_r     <= '0;
      marks1_r    <= '0;
      marks2_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      cut_r       <= cut_nxt;
      slot1_r     <= slot1_nxt;
      slot2_r     <= slot2_nxt;
      marks1_r    <= marks1_nxt;
      marks2_r    <= marks2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // parent and child stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (par_we) begin
      first_mem[in_pos]  <= in_c1;
      second_mem[in_pos] <= in_c2;
    end
    if (c1_we) begin
      child1_mem[slot1_r[CITY_W-1:0]] <= second_q_r;
    end
    if (c2_we) begin
      child2_mem[slot2_r[CITY_W-1:0]] <= first_q_r;
    end
    first_q_r  <= first_mem[idx_r];
    second_q_r <= second_mem[idx_r];
    child1_q_r <= child1_mem[idx_r];
    child2_q_r <= child2_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos_r  <= idx_r;
      out_c1_r   <= sel_c1;
      out_c2_r   <= sel_c2;
      out_last_r <= (idx_r == LAST_POS);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_c2_r, out_c1_r, out_pos_r};
  assign out_tlast  = out_last_r;

  a_cut_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (cut_r >= CUT_LO && cut_r <= CUT_HI))
    else $error("cut outside clamp range");

  a_mark_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) |-> (idx_ext < cut_r))
    else $error("mark pass past cut");

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL || state_r == ST_EMIT) |->
      (slot1_r <= TOUR_LEN && slot2_r <= TOUR_LEN && slot1_r >= cut_r))
    else $error("fill slot out of range");

  a_marks_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> ($countones(marks1_r) <= cut_r))
    else $error("prefix marks exceed cut");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == ST_EMIT))
    else $error("output raised outside emit pass");

endmodule

// ===== dv/permutation_order_crossover_checker.sv =====
// checker for the order crossover core: watches both stream channels,
// predicts the two children of every crossover and compares each child transaction
// depends on poc_pkg
module permutation_order_crossover_checker
  import poc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    expected_left,
  output int                    crossovers,
  output int                    results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    city_t position;
    city_t child_first;
    city_t child_second;
    logic  final_pos;
  } child_pair_t;

  city_t       first_tour   [STORE_DEPTH];
  city_t       second_tour  [STORE_DEPTH];
  city_t       first_child  [STORE_DEPTH];
  city_t       second_child [STORE_DEPTH];
  mark_t       first_marks;
  mark_t       second_marks;
  child_pair_t child_queue  [$];
  child_pair_t want;
  city_t       pair_pos;
  int          cut_pt;
  int          slot_a;
  int          slot_b;

  task automatic report_mismatch(input string what, input int got, input int wanted);
    if (fail_count < 20) begin
      if (wanted < 0) begin
        $display("mismatch: %s %0d, nothing expected", what, got);
      end else begin
        $display("mismatch: %s at child transaction %0d: got %0d, expected %0d",
                 what, results_checked, got, wanted);
      end
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      first_marks = '0;
      second_marks = '0;
      child_queue.delete();
      expected_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (child_queue.size() == 0) begin
          report_mismatch("child transaction with position", out_tdata[4:0], -1);
        end else begin
          want = child_queue.pop_front();
          if (out_tdata[4:0] !== want.position)
            report_mismatch("position", out_tdata[4:0], want.position);
          if (out_tdata[9:5] !== want.child_first)
            report_mismatch("first child city", out_tdata[9:5], want.child_first);
          if (out_tdata[14:10] !== want.child_second)
            report_mismatch("second child city", out_tdata[14:10], want.child_second);
          if (out_tlast !== want.final_pos)
            report_mismatch("tlast", out_tlast, want.final_pos);
        end
        results_checked++;
      end

      if (in_tvalid && in_tready) begin
        pair_pos = in_tdata[4:0];
        if (int'(pair_pos) < TOUR_LEN_I) begin
          first_tour[pair_pos] = in_tdata[9:5];
          second_tour[pair_pos] = in_tdata[14:10];
        end
        if (in_tlast) begin
          cut_pt = int'(in_tdata[20:15]);
          if (cut_pt < TOUR_LEN_I / 2) cut_pt = TOUR_LEN_I / 2;
          if (cut_pt > TOUR_LEN_I - 2) cut_pt = TOUR_LEN_I - 2;

          // cities held in each parent prefix
          first_marks = '0;
          second_marks = '0;
          for (int i = 0; i < cut_pt; i++) begin
            first_marks[first_tour[i]] = 1'b1;
            second_marks[second_tour[i]] = 1'b1;
          end

          for (int i = 0; i < STORE_DEPTH; i++) begin
            first_child[i] = first_tour[i];
            second_child[i] = second_tour[i];
          end

          // fill from the other parent, skipping prefix cities, surplus dropped
          slot_a = cut_pt;
          slot_b = cut_pt;
          for (int i = 1; i < TOUR_LEN_I; i++) begin
            if (!first_marks[second_tour[i]] && slot_a < TOUR_LEN_I) begin
              first_child[slot_a] = second_tour[i];
              slot_a++;
            end
            if (!second_marks[first_tour[i]] && slot_b < TOUR_LEN_I) begin
              second_child[slot_b] = first_tour[i];
              slot_b++;
            end
          end

          for (int i = 0; i < TOUR_LEN_I; i++) begin
            child_queue.push_back('{position:     city_t'(i),
                                   child_first:  first_child[i],
                                   child_second: second_child[i],
                                   final_pos:    (i == TOUR_LEN_I - 1)});
          end
          crossovers++;
        end
      end
      expected_left = child_queue.size();
    end
  end

endmodule

// ===== dv/permutation_order_crossover_core_tb.sv =====
// top of the order crossover regression: clock, reset, parent tour stimulus
// with bursty sender and stalling receiver, and the verdict
// depends on poc_pkg, permutation_order_crossover_core and permutation_order_crossover_checker
module permutation_order_crossover_core_tb
  import poc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {READY_ALWAYS, READY_PATTERN, READY_RANDOM, READY_SPARSE} ready_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  int fail_count;
  int expected_left;
  int crossovers;
  int results_checked;

  city_t tour_a [STORE_DEPTH];
  city_t tour_b [STORE_DEPTH];
  int    order  [STORE_DEPTH];
  int    cut_edges [6];
  int    burst_left;
  int    items_sent;

  permutation_order_crossover_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  permutation_order_crossover_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .fail_count      (fail_count),
    .expected_left   (expected_left),
    .crossovers      (crossovers),
    .results_checked (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("permutation_order_crossover_core regression: fail");
    $finish;
  end

  // receiver: stall behavior switches mode after each random span
  initial begin
    ready_mode_t  mode;
    int           span;
    int           step;
    logic [15:0]  pattern;
    out_tready <= 1'b0;
    mode = READY_ALWAYS;
    span = 0;
    step = 0;
    pattern = 16'hffff;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        mode = ready_mode_t'($urandom_range(0, 3));
        span = $urandom_range(16, 160);
        pattern = 16'($urandom) | 16'h0001;
      end
      case (mode)
        READY_ALWAYS:  out_tready <= 1'b1;
        READY_PATTERN: out_tready <= pattern[step % 16];
        READY_RANDOM:  out_tready <= 1'($urandom_range(0, 1));
        default:       out_tready <= ($urandom_range(0, 3) == 0);
      endcase
      span--;
      step++;
    end
  end

  task automatic send_pair(input int pos, input int city_a, input int city_b, input int cut,
                           input bit last_pair);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        in_tdata <= IN_DATA_W'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_DATA_W'({6'(cut), city_t'(city_b), city_t'(city_a), city_t'(pos)});
    in_tlast <= last_pair;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_tour(input int cut);
    for (int k = 0; k < TOUR_LEN_I; k++) begin
      send_pair(order[k], tour_a[order[k]], tour_b[order[k]], cut, k == TOUR_LEN_I - 1);
    end
  endtask

  // two random tours with city 0 first, optionally sent in shuffled position order
  task automatic make_tours(input bit scramble);
    int    j;
    int    o;
    city_t t;
    for (int i = 0; i < TOUR_LEN_I; i++) begin
      tour_a[i] = city_t'(i);
      tour_b[i] = city_t'(i);
      order[i] = i;
    end
    for (int i = TOUR_LEN_I - 1; i > 1; i--) begin
      j = $urandom_range(1, i);
      t = tour_a[i]; tour_a[i] = tour_a[j]; tour_a[j] = t;
      j = $urandom_range(1, i);
      t = tour_b[i]; tour_b[i] = tour_b[j]; tour_b[j] = t;
    end
    if (scramble) begin
      for (int i = TOUR_LEN_I - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        o = order[i]; order[i] = order[j]; order[j] = o;
      end
    end
  endtask

  initial begin
    int kind;
    int count;
    int cut;
    int directed_items;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    burst_left = 0;
    items_sent = 0;
    cut_edges = '{0, TOUR_LEN_I / 2 - 1, TOUR_LEN_I / 2, TOUR_LEN_I - 2, TOUR_LEN_I - 1, 63};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity against reversed tour, every store entry written once
    for (int i = 0; i < TOUR_LEN_I; i++) begin
      tour_a[i] = city_t'(i);
      tour_b[i] = (i == 0) ? city_t'(0) : city_t'(TOUR_LEN_I - i);
      order[i] = i;
    end
    send_tour(0);

    // single and multi transaction crossovers on the kept stores, cut edges and broken tours
    send_pair(0, 0, 0, 63, 1'b1);
    send_pair(1, 1, 31, TOUR_LEN_I - 1, 1'b1);
    send_pair(2, 31, 0, TOUR_LEN_I - 2, 1'b1);
    send_pair(3, 0, 31, TOUR_LEN_I / 2, 1'b1);
    send_pair(4, 31, 31, TOUR_LEN_I / 2 - 1, 1'b1);
    send_pair(5, 0, 0, 63, 1'b0);
    send_pair(6, 31, 31, 0, 1'b0);
    send_pair(TOUR_LEN_I - 1, 0, 31, 42, 1'b1);
    directed_items = items_sent;

    while (items_sent < directed_items + 80) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        make_tours($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) begin
          tour_a[$urandom_range(1, TOUR_LEN_I - 1)] = city_t'($urandom_range(0, 31));
          tour_b[$urandom_range(0, TOUR_LEN_I - 1)] = city_t'($urandom_range(0, 31));
        end
        cut = ($urandom_range(0, 2) == 0) ? cut_edges[$urandom_range(0, 5)]
                                          : $urandom_range(0, 63);
        send_tour(cut);
      end else if (kind < 8) begin
        count = $urandom_range(1, 6);
        for (int k = 0; k < count; k++) begin
          send_pair($urandom_range(0, TOUR_LEN_I - 1), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 63), k == count - 1);
        end
      end else begin
        count = $urandom_range(1, 4);
        for (int k = 0; k < count; k++) begin
          send_pair($urandom_range(0, TOUR_LEN_I - 1), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 63), 1'b0);
        end
      end
    end
    in_tvalid <= 1'b0;
    @(posedge clk);

    while (expected_left != 0) @(posedge clk);
    repeat (250) @(posedge clk);

    $display("sent %0d parent pair transactions, %0d of them starting a crossover",
             items_sent, crossovers);
    $display("compared %0d child transactions with the predicted children", results_checked);
    if (fail_count == 0 && expected_left == 0) begin
      $display("permutation_order_crossover_core regression: pass");
    end else begin
      $display("permutation_order_crossover_core regression: fail");
    end
    $finish;
  end

endmodule
